@@ src/grc_pkg.sv @@
package grc_pkg;

  localparam int CAM_W   = 23;
  localparam int RAY_W   = 27;
  localparam int DIV_NW  = 40;
  localparam int DIV_DW  = 32;
  localparam int DELTA_W = 32;

  localparam logic [DELTA_W-1:0] DELTA_SAT = '1;
  localparam logic [15:0]        DIST_SAT  = 16'hFFFF;

  typedef enum logic [2:0] {
    CFG_POS_X   = 3'd0,
    CFG_POS_Y   = 3'd1,
    CFG_DIR_X   = 3'd2,
    CFG_DIR_Y   = 3'd3,
    CFG_PLANE_X = 3'd4,
    CFG_PLANE_Y = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_CAST  = 1'b1
  } op_e;

  typedef struct packed {
    logic        [14:0] pos_x;
    logic        [14:0] pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
  } cfg_t;

  // declared from the top bit down so that out_column sits in the lowest bits
  typedef struct packed {
    logic [8:0]  slice_bot;
    logic [8:0]  slice_top;
    logic [15:0] wall_distance;
    logic        hit_side;
    logic [7:0]  hit_value;
    logic [4:0]  hit_y;
    logic [4:0]  hit_x;
    logic        hit_found;
    logic [9:0]  out_column;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CAM,
    S_MUL,
    S_RAY,
    S_DX,
    S_DX_WAIT,
    S_DY,
    S_DY_WAIT,
    S_SIDE,
    S_STEP,
    S_CHECK,
    S_DIST,
    S_DIST_WAIT,
    S_LINE,
    S_LINE_WAIT,
    S_DRAW,
    S_DONE
  } caster_state_e;

endpackage

@@ src/grc_map_ram.sv @@
module grc_map_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ src/grc_div.sv @@
module grc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [grc_pkg::DIV_NW-1:0] num_i,
  input  logic [grc_pkg::DIV_DW-1:0] den_i,
  output logic                       done_o,
  output logic [grc_pkg::DIV_NW-1:0] quo_o
);

  import grc_pkg::*;

  localparam int ITER  = DIV_NW / 2;
  localparam int CNT_W = $clog2(ITER);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIV_DW-1:0] rem_q, den_q, rem_d;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW:0]   t1, t2;
  logic [DIV_DW-1:0] r1;
  logic              q1, q2;

  // two restoring steps per cycle
  always_comb begin
    t1 = {rem_q, quo_q[DIV_NW-1]};
    q1 = (t1 >= {1'b0, den_q});
    r1 = q1 ? DIV_DW'(t1 - {1'b0, den_q}) : t1[DIV_DW-1:0];
    t2 = {r1, quo_q[DIV_NW-2]};
    q2 = (t2 >= {1'b0, den_q});
    rem_d = q2 ? DIV_DW'(t2 - {1'b0, den_q}) : t2[DIV_DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ITER - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DIV_NW-3:0], q1, q2};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ src/grc_caster.sv @@
module grc_caster #(
  parameter int MAP_W    = 32,
  parameter int MAP_H    = 32,
  parameter int SCREEN_W = 640,
  parameter int SCREEN_H = 480
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  grc_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  grc_pkg::op_e   in_op_i,
  input  logic [4:0]     cell_x_i,
  input  logic [4:0]     cell_y_i,
  input  logic [7:0]     cell_value_i,
  input  logic [9:0]     column_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output grc_pkg::res_t  res_o
);

  import grc_pkg::*;

  localparam int MXW    = (($clog2(MAP_W) > 5) ? $clog2(MAP_W) : 5) + 2;
  localparam int MYW    = (($clog2(MAP_H) > 5) ? $clog2(MAP_H) : 5) + 2;
  localparam int DEPTH  = MAP_W * MAP_H;
  localparam int AW     = $clog2(DEPTH);
  localparam int NSTEPS = MAP_W + MAP_H;
  localparam int CNT_W  = $clog2(NSTEPS + 1);
  localparam int SIDE_W = 43 + CNT_W + 1;
  localparam int NMW    = ((MXW > MYW) ? MXW : MYW) + 12;
  localparam int LINE_W = $clog2(SCREEN_H) + 11;
  localparam int DRAW_W = LINE_W + 2;
  localparam int PROD_W = CAM_W + 16;
  // column * 2^15 / SCREEN_W by reciprocal; exact for column < 2^10, SCREEN_W <= 2^12
  localparam int CAM_K  = 37;
  localparam int CAM_SH = CAM_K - 15;
  localparam logic [33:0] CAM_RECIP =
    34'(((64'd1 << CAM_K) + 64'(SCREEN_W) - 64'd1) / 64'(SCREEN_W));

  caster_state_e state_q, state_d;

  logic [9:0]               col_q;
  logic [43:0]              cam_prod;
  logic signed [CAM_W-1:0]  cam_q;
  logic signed [PROD_W-1:0] prodx_q, prody_q, shx, shy;
  logic signed [RAY_W-1:0]  rx_q, ry_q;
  logic [RAY_W-1:0]         magx, magy, rm;
  logic [DELTA_W-1:0]       dx_q, dy_q;
  logic [SIDE_W-1:0]        sidex_q, sidey_q;
  logic [MXW-1:0]           mx_q, mx_nx;
  logic [MYW-1:0]           my_q, my_nx;
  logic [CNT_W-1:0]         nstep_q;
  logic                     side_q, hit_q, step_x, off_map;
  logic [7:0]               val_q;
  logic [15:0]              dist_q;
  logic [LINE_W-1:0]        line_q;
  logic [8:0]               ds_q, de_q;
  logic [10:0]              fracx, fracy;
  logic [42:0]              psx, psy;
  logic [NMW-1:0]           num, num_mag;
  logic signed [DRAW_W-1:0] ds_s, de_s;

  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  logic in_take, cast_take;

  assign in_take   = (state_q == S_IDLE) && in_valid_i;
  assign cast_take = in_take && (in_op_i == OP_CAST);

  assign cam_prod = col_q * CAM_RECIP;

  assign magx = rx_q[RAY_W-1] ? RAY_W'(-rx_q) : RAY_W'(rx_q);
  assign magy = ry_q[RAY_W-1] ? RAY_W'(-ry_q) : RAY_W'(ry_q);
  assign rm   = side_q ? magy : magx;
  assign shx  = prodx_q >>> 14;
  assign shy  = prody_q >>> 14;

  assign fracx = rx_q[RAY_W-1] ? {1'b0, cfg_i.pos_x[9:0]} : 11'd1024 - {1'b0, cfg_i.pos_x[9:0]};
  assign fracy = ry_q[RAY_W-1] ? {1'b0, cfg_i.pos_y[9:0]} : 11'd1024 - {1'b0, cfg_i.pos_y[9:0]};
  assign psx   = fracx * dx_q;
  assign psy   = fracy * dy_q;

  // one DDA step: advance x if its side distance is strictly shorter, else y (y wins a tie)
  always_comb begin
    step_x = (sidex_q < sidey_q);
    mx_nx  = mx_q;
    my_nx  = my_q;
    if (step_x) begin
      mx_nx = rx_q[RAY_W-1] ? mx_q - MXW'(1) : mx_q + MXW'(1);
    end else begin
      my_nx = ry_q[RAY_W-1] ? my_q - MYW'(1) : my_q + MYW'(1);
    end
    off_map = (mx_nx >= MXW'(MAP_W)) || (my_nx >= MYW'(MAP_H));
    ram_raddr = AW'(32'(my_nx) * MAP_W + 32'(mx_nx));
  end

  // perpendicular distance numerator on the struck side
  always_comb begin
    if (side_q) begin
      num = NMW'({my_q, 10'b0}) - NMW'(cfg_i.pos_y)
          + (ry_q[RAY_W-1] ? NMW'(1024) : NMW'(0));
    end else begin
      num = NMW'({mx_q, 10'b0}) - NMW'(cfg_i.pos_x)
          + (rx_q[RAY_W-1] ? NMW'(1024) : NMW'(0));
    end
    num_mag = num[NMW-1] ? NMW'(-num) : num;
  end

  always_comb begin
    ds_s = DRAW_W'(SCREEN_H / 2) - DRAW_W'(line_q >> 1);
    de_s = DRAW_W'(SCREEN_H / 2) + DRAW_W'(line_q >> 1);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (cast_take) state_d = S_CAM;
      S_CAM:       state_d = S_MUL;
      S_MUL:       state_d = S_RAY;
      S_RAY:       state_d = S_DX;
      S_DX:        state_d = (magx == '0) ? S_DY : S_DX_WAIT;
      S_DX_WAIT:   if (div_done) state_d = S_DY;
      S_DY:        state_d = (magy == '0) ? S_SIDE : S_DY_WAIT;
      S_DY_WAIT:   if (div_done) state_d = S_SIDE;
      S_SIDE:      state_d = S_STEP;
      S_STEP: begin
        if (nstep_q == CNT_W'(NSTEPS) || off_map) begin
          state_d = S_DONE;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK:     state_d = (ram_rdata != 8'd0) ? S_DIST : S_STEP;
      S_DIST:      state_d = (rm == '0) ? S_LINE : S_DIST_WAIT;
      S_DIST_WAIT: if (div_done) state_d = S_LINE;
      S_LINE:      state_d = (dist_q == 16'd0) ? S_DONE : S_LINE_WAIT;
      S_LINE_WAIT: if (div_done) state_d = S_DRAW;
      S_DRAW:      state_d = S_DONE;
      S_DONE:      if (res_ready_i) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    res_valid_o = (state_q == S_DONE);
    ram_we      = in_take && (in_op_i == OP_WRITE)
                  && (32'(cell_x_i) < MAP_W) && (32'(cell_y_i) < MAP_H);
    ram_waddr   = AW'(32'(cell_y_i) * MAP_W + 32'(cell_x_i));
    ram_re      = (state_q == S_STEP) && (nstep_q != CNT_W'(NSTEPS)) && !off_map;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    unique case (state_q)
      S_DX: begin
        div_start = (magx != '0);
        div_num   = DIV_NW'(1) << 28;
        div_den   = DIV_DW'(magx);
      end
      S_DY: begin
        div_start = (magy != '0);
        div_num   = DIV_NW'(1) << 28;
        div_den   = DIV_DW'(magy);
      end
      S_DIST: begin
        div_start = (rm != '0);
        div_num   = DIV_NW'({num_mag, 14'b0});
        div_den   = DIV_DW'(rm);
      end
      S_LINE: begin
        div_start = (dist_q != 16'd0);
        div_num   = DIV_NW'(SCREEN_H * 1024);
        div_den   = DIV_DW'(dist_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        col_q <= column_i;
        hit_q <= 1'b0;
      end
      S_CAM: begin
        cam_q <= $signed({1'b0, cam_prod[CAM_SH +: CAM_W-1]}) - CAM_W'(16384);
      end
      S_MUL: begin
        prodx_q <= cfg_i.plane_x * cam_q;
        prody_q <= cfg_i.plane_y * cam_q;
      end
      S_RAY: begin
        rx_q <= $signed(shx[RAY_W-1:0] + {{(RAY_W-16){cfg_i.dir_x[15]}}, cfg_i.dir_x});
        ry_q <= $signed(shy[RAY_W-1:0] + {{(RAY_W-16){cfg_i.dir_y[15]}}, cfg_i.dir_y});
      end
      S_DX:      if (magx == '0) dx_q <= DELTA_SAT;
      S_DX_WAIT: if (div_done) dx_q <= div_quo[DELTA_W-1:0];
      S_DY:      if (magy == '0) dy_q <= DELTA_SAT;
      S_DY_WAIT: if (div_done) dy_q <= div_quo[DELTA_W-1:0];
      S_SIDE: begin
        sidex_q <= SIDE_W'(psx);
        sidey_q <= SIDE_W'(psy);
        mx_q    <= MXW'(cfg_i.pos_x[14:10]);
        my_q    <= MYW'(cfg_i.pos_y[14:10]);
        nstep_q <= '0;
      end
      S_STEP: begin
        if (step_x) begin
          sidex_q <= sidex_q + SIDE_W'({dx_q, 10'b0});
        end else begin
          sidey_q <= sidey_q + SIDE_W'({dy_q, 10'b0});
        end
        mx_q    <= mx_nx;
        my_q    <= my_nx;
        side_q  <= !step_x;
        nstep_q <= nstep_q + CNT_W'(1);
      end
      S_CHECK: begin
        val_q <= ram_rdata;
        if (ram_rdata != 8'd0) hit_q <= 1'b1;
      end
      S_DIST:      if (rm == '0) dist_q <= DIST_SAT;
      S_DIST_WAIT: begin
        if (div_done) begin
          dist_q <= (|div_quo[DIV_NW-1:16]) ? DIST_SAT : div_quo[15:0];
        end
      end
      S_LINE: begin
        if (dist_q == 16'd0) begin
          ds_q <= '0;
          de_q <= 9'(SCREEN_H - 1);
        end
      end
      S_LINE_WAIT: if (div_done) line_q <= div_quo[LINE_W-1:0];
      S_DRAW: begin
        ds_q <= (ds_s < 0) ? 9'd0 : ds_s[8:0];
        de_q <= (de_s >= DRAW_W'(SCREEN_H)) ? 9'(SCREEN_H - 1) : de_s[8:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o            = '0;
    res_o.out_column = col_q;
    res_o.wall_distance = DIST_SAT;
    if (hit_q) begin
      res_o.hit_found     = 1'b1;
      res_o.hit_x         = mx_q[4:0];
      res_o.hit_y         = my_q[4:0];
      res_o.hit_value     = val_q;
      res_o.hit_side      = side_q;
      res_o.wall_distance = dist_q;
      res_o.slice_top     = ds_q;
      res_o.slice_bot     = de_q;
    end
  end

  grc_map_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(cell_value_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  grc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

endmodule

@@ src/grid_raycast_column_core.sv @@
// channel  | dir | handshake               | payload
// s_axis   | in  | s_axis_tvalid/tready    | tdata cell fields, tuser op
// m_axis   | out | m_axis_tvalid/tready    | tdata result fields
// cfg      | in  | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
// A cast that hits runs up to four divisions on the shared two-bit-per-cycle divider
// (one fewer for each zero ray component or zero wall distance), plus a read and a
// test of the map memory for every cell walked, at most MAP_W+MAP_H cells; a miss
// skips the last two divisions.
// Reset clears control state and loads the default config; the map holds garbage until written.
// A result waits in the output register while the next item runs.
module grid_raycast_column_core #(
  parameter int MAP_W    = 32,
  parameter int MAP_H    = 32,
  parameter int SCREEN_W = 640,
  parameter int SCREEN_H = 480
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cell_x[4:0], cell_y[9:5], cell_value[17:10], column[27:18], zero fill
  input  logic [31:0] s_axis_tdata,
  // op[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_column[9:0], hit_found[10], hit_x[15:11], hit_y[20:16],
  // hit_value[28:21], hit_side[29], wall_distance[45:30],
  // slice_top[54:46], slice_bot[63:55]
  output logic [63:0] m_axis_tdata
);

  import grc_pkg::*;

  cfg_t cfg_q;
  res_t res, out_q;
  logic out_valid_q, res_valid, res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_x   <= 15'd0;
      cfg_q.pos_y   <= 15'd0;
      cfg_q.dir_x   <= -16'sd16384;
      cfg_q.dir_y   <= 16'sd0;
      cfg_q.plane_x <= 16'sd0;
      cfg_q.plane_y <= 16'sd10813;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_POS_X:   cfg_q.pos_x   <= cfg_data_i[14:0];
        CFG_POS_Y:   cfg_q.pos_y   <= cfg_data_i[14:0];
        CFG_DIR_X:   cfg_q.dir_x   <= $signed(cfg_data_i);
        CFG_DIR_Y:   cfg_q.dir_y   <= $signed(cfg_data_i);
        CFG_PLANE_X: cfg_q.plane_x <= $signed(cfg_data_i);
        CFG_PLANE_Y: cfg_q.plane_y <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // output register: load when empty or draining
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  grc_caster #(
    .MAP_W   (MAP_W),
    .MAP_H   (MAP_H),
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
  ) u_caster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (op_e'(s_axis_tuser[0])),
    .cell_x_i    (s_axis_tdata[4:0]),
    .cell_y_i    (s_axis_tdata[9:5]),
    .cell_value_i(s_axis_tdata[17:10]),
    .column_i    (s_axis_tdata[27:18]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  a_idle_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && res_valid))
    else $error("caster accepts input while holding a result");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result changed before transfer");

  a_miss_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !out_q.hit_found |->
      out_q.wall_distance == DIST_SAT && out_q.slice_bot == 9'd0)
    else $error("miss result carries hit fields");

endmodule
